### rtl/core/erfinv_pkg.sv
// ----------------------------------------------------------------------------
// erfinv_pkg: shared types and constants for the inverse error function unit
// Fixed-point formats, cell word layouts and the Q30 polynomial coefficient
// tables for the central and tail branches.
// ----------------------------------------------------------------------------
package erfinv_pkg;

   // Input and output fraction bits
   localparam int IN_FRAC_BITS  = 23;
   localparam int OUT_FRAC_BITS = 20;

   // Field width of argument and inverse_value
   localparam int Y_W = 24;

   // Fraction bits of w (log domain) and of the coefficients
   localparam int WQ = 28;
   localparam int CQ = 30;

   // 1 - y*y, padded so that a Q1.30 mantissa can always be taken from the top
   localparam int D_W   = (2 * IN_FRAC_BITS + 1 < 31) ? 31 : 2 * IN_FRAC_BITS + 1;
   localparam int D_OFF = D_W - 1 - 2 * IN_FRAC_BITS;
   localparam int LZ_W  = $clog2(D_W);

   // Normalizer cells each strip up to NORM_STEP leading zeros
   localparam int NORM_STEP  = 8;
   localparam int NORM_CELLS = (D_W - 1 + NORM_STEP - 1) / NORM_STEP;
   localparam int CNT_W      = $clog2(NORM_STEP + 1);

   // Log2 mantissa in Q1.30, one fraction bit per cell
   localparam int M_W       = 31;
   localparam int M_FRAC    = M_W - 1;
   localparam int LOG_CELLS = WQ;

   // w and square root widths
   localparam int W_W    = $clog2(2 * IN_FRAC_BITS + 1) + WQ;
   localparam int V_W    = 2 * ((W_W + WQ + 1) / 2);
   localparam int ROOT_W = V_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int T_W    = ROOT_W + 1;

   // Horner accumulator in Q30, split into two partial products per step
   localparam int X_W          = 36;
   localparam int XL_W         = 18;
   localparam int XH_W         = X_W - XL_W;
   localparam int HORNER_CELLS = 8;

   // Final scaling shift from Q30 * Q(IN) down to Q(OUT)
   localparam int RES_SHIFT = CQ + IN_FRAC_BITS - OUT_FRAC_BITS;

   // ln 2 in Q28, rounded to nearest
   localparam longint LN2_Q28_L =
      (64'sd6931471806 * 64'sd268435456 + 64'sd5000000000) / 64'sd10000000000;
   localparam logic [WQ-1:0] LN2_Q28 = WQ'(LN2_Q28_L);

   // Central branch coefficients, Q30, highest order first
   localparam logic signed [X_W-1:0] CENTRAL_COEF [0:8] = '{
      X_W'((64'sd281022636 * 64'sd1073741824 + 64'sd5000000000000000)
           / 64'sd10000000000000000),
      X_W'((64'sd343273939 * 64'sd1073741824 + 64'sd500000000000000)
           / 64'sd1000000000000000),
      X_W'(-((64'sd352338770 * 64'sd1073741824 + 64'sd50000000000000)
           / 64'sd100000000000000)),
      X_W'(-((64'sd439150654 * 64'sd1073741824 + 64'sd50000000000000)
           / 64'sd100000000000000)),
      X_W'((64'sd218580870 * 64'sd1073741824 + 64'sd500000000000)
           / 64'sd1000000000000),
      X_W'(-((64'sd125372503 * 64'sd1073741824 + 64'sd50000000000)
           / 64'sd100000000000)),
      X_W'(-((64'sd417768164 * 64'sd1073741824 + 64'sd50000000000)
           / 64'sd100000000000)),
      X_W'((64'sd246640727 * 64'sd1073741824 + 64'sd500000000)
           / 64'sd1000000000),
      X_W'((64'sd150140941 * 64'sd1073741824 + 64'sd50000000)
           / 64'sd100000000)
   };

   // Tail branch coefficients, Q30, highest order first
   localparam logic signed [X_W-1:0] TAIL_COEF [0:8] = '{
      X_W'(-((64'sd200214257 * 64'sd1073741824 + 64'sd500000000000)
           / 64'sd1000000000000)),
      X_W'((64'sd100950558 * 64'sd1073741824 + 64'sd500000000000)
           / 64'sd1000000000000),
      X_W'((64'sd134934322 * 64'sd1073741824 + 64'sd50000000000)
           / 64'sd100000000000),
      X_W'(-((64'sd367342844 * 64'sd1073741824 + 64'sd50000000000)
           / 64'sd100000000000)),
      X_W'((64'sd573950773 * 64'sd1073741824 + 64'sd50000000000)
           / 64'sd100000000000),
      X_W'(-((64'sd762246130 * 64'sd1073741824 + 64'sd50000000000)
           / 64'sd100000000000)),
      X_W'((64'sd943887047 * 64'sd1073741824 + 64'sd50000000000)
           / 64'sd100000000000),
      X_W'((64'sd100167406 * 64'sd1073741824 + 64'sd50000000)
           / 64'sd100000000),
      X_W'((64'sd283297682 * 64'sd1073741824 + 64'sd50000000)
           / 64'sd100000000)
   };

   // Per-item tag carried down the whole chain
   typedef struct packed {
      logic                  sat;
      logic signed [Y_W-1:0] y;
   } tag_type;

   typedef struct packed {
      logic            valid;
      tag_type         tag;
      logic [D_W-1:0]  d;
      logic [LZ_W-1:0] lz;
   } norm_word_type;

   typedef struct packed {
      logic            valid;
      tag_type         tag;
      logic [LZ_W-1:0] lz;
      logic [M_W-1:0]  m;
      logic [WQ-1:0]   frac;
   } log_word_type;

   typedef struct packed {
      logic                  valid;
      tag_type               tag;
      logic                  central;
      logic signed [T_W-1:0] tc;
      logic [V_W-1:0]        v;
      logic [REM_W-1:0]      rem;
      logic [ROOT_W-1:0]     root;
   } sqrt_word_type;

   typedef struct packed {
      logic                  valid;
      tag_type               tag;
      logic                  central;
      logic signed [T_W-1:0] t;
      logic signed [X_W-1:0] x;
   } horner_word_type;

endpackage

### rtl/core/inverse_error_function_unit.sv
// ----------------------------------------------------------------------------
// inverse_error_function_unit: pipelined erfinv(y), Q1.23 in, Q4.20 out
// Throughput: one word per cycle while the skid slot is empty; every cell of the
// chain advances in each such cycle. The longest chains are the 31-cell square
// root and 28-cell log2 chains, all pipelined. Backpressure: an output register
// plus one skid slot; req_tready drops only while the skid slot is occupied.
// Reset clears all valid bits, no sweep.
module inverse_error_function_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [erfinv_pkg::Y_W-1:0]   req_tdata,   // [23:0] argument
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [erfinv_pkg::Y_W-1:0]   rsp_tdata    // [23:0] inverse_value
);
   import erfinv_pkg::*;

   localparam int U_W    = (2 * IN_FRAC_BITS + 1 > 2 * Y_W) ? 2 * IN_FRAC_BITS + 1 : 2 * Y_W;
   localparam int P_W    = LZ_W + 2 * WQ + 1;
   localparam int PROD_W = X_W + Y_W;

   localparam logic [U_W-1:0]          UNITY   = U_W'(1) << (2 * IN_FRAC_BITS);
   localparam logic [W_W-1:0]          W_SPLIT = W_W'(5) << WQ;
   localparam logic [W_W-1:0]          W_MID   = W_W'(5) << (WQ - 1);
   localparam logic signed [T_W-1:0]   ROOT_3  = T_W'(3) <<< WQ;
   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(2 ** (Y_W - 1) - 1);
   localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-(2 ** (Y_W - 1)));

   typedef struct packed {
      logic                  valid;
      logic signed [Y_W-1:0] y;
   } in_type;

   typedef struct packed {
      logic                  valid;
      logic signed [Y_W-1:0] y;
      logic [2*Y_W-1:0]      ysq;
   } sq_type;

   typedef struct packed {
      logic                  valid;
      tag_type               tag;
      logic [LZ_W+WQ-1:0]    p1;
      logic [2*WQ-1:0]       p2;
   } scale_type;

   typedef struct packed {
      logic                  valid;
      tag_type               tag;
      logic signed [PROD_W-1:0] prod;
   } fin_type;

   typedef struct packed {
      logic                  valid;
      logic [Y_W-1:0]        res;
   } res_type;

   logic                   advance;
   in_type                 in_ff, in_in;
   sq_type                 sq_ff, sq_in;
   norm_word_type          norm_head_ff, norm_head_in;
   norm_word_type          norm_w [0:NORM_CELLS];
   log_word_type           log_head;
   log_word_type           log_w  [0:LOG_CELLS];
   scale_type              scale_ff, scale_in;
   sqrt_word_type          sqrt_head_ff, sqrt_head_in;
   sqrt_word_type          sqrt_w [0:ROOT_W];
   horner_word_type        sel_ff, sel_in;
   horner_word_type        horner_w [0:HORNER_CELLS];
   fin_type                fin_ff, fin_in;
   res_type                res_ff, res_in;

   logic [Y_W-1:0]         mag;
   logic [U_W-1:0]         ysq_ext;
   logic                   sat_now;
   logic [LZ_W-1:0]        expo;
   logic [P_W-1:0]         p_sum;
   logic [W_W-1:0]         w_val;
   logic signed [W_W:0]    tc_full;
   logic signed [PROD_W-1:0] rnd;

   logic                   out_valid_ff, out_valid_in;
   logic [Y_W-1:0]         out_data_ff, out_data_in;
   logic                   skid_valid_ff, skid_valid_in;
   logic [Y_W-1:0]         skid_data_ff, skid_data_in;

   // Hold the whole chain while the skid slot is occupied
   assign advance    = !skid_valid_ff;
   assign req_tready = advance;

   // Capture the input word
   always_comb begin
      in_in.valid = req_tvalid;
      in_in.y     = req_tdata;
   end

   // Square the magnitude
   always_comb begin
      mag          = in_ff.y[Y_W-1] ? Y_W'(-in_ff.y) : Y_W'(in_ff.y);
      sq_in.valid  = in_ff.valid;
      sq_in.y      = in_ff.y;
      sq_in.ysq    = mag * mag;
   end

   // Form 1 - y*y, flag magnitudes at or beyond one
   always_comb begin
      ysq_ext              = U_W'(sq_ff.ysq);
      sat_now              = ysq_ext >= UNITY;
      norm_head_in.valid   = sq_ff.valid;
      norm_head_in.tag.sat = sat_now;
      norm_head_in.tag.y   = sq_ff.y;
      norm_head_in.d       = sat_now ? D_W'(1) : D_W'(UNITY - ysq_ext);
      norm_head_in.lz      = '0;
   end

   assign norm_w[0] = norm_head_ff;

   // Normalizer chain
   for (genvar i = 0; i < NORM_CELLS; i++) begin : g_norm
      erfinv_norm_cell u_norm (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .src_word (norm_w[i]),
         .dst_word (norm_w[i+1])
      );
   end

   // Hand the Q1.30 mantissa to the log2 chain
   always_comb begin
      log_head.valid = norm_w[NORM_CELLS].valid;
      log_head.tag   = norm_w[NORM_CELLS].tag;
      log_head.lz    = norm_w[NORM_CELLS].lz;
      log_head.m     = norm_w[NORM_CELLS].d[D_W-1 -: M_W];
      log_head.frac  = '0;
   end

   assign log_w[0] = log_head;

   // Log2 chain
   for (genvar i = 0; i < LOG_CELLS; i++) begin : g_log
      erfinv_log_cell u_log (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .src_word (log_w[i]),
         .dst_word (log_w[i+1])
      );
   end

   // Scale by ln 2: integer part and fraction part products
   always_comb begin
      expo           = LZ_W'(log_w[LOG_CELLS].lz - LZ_W'(D_OFF));
      scale_in.valid = log_w[LOG_CELLS].valid;
      scale_in.tag   = log_w[LOG_CELLS].tag;
      scale_in.p1    = expo * LN2_Q28;
      scale_in.p2    = log_w[LOG_CELLS].frac * LN2_Q28;
   end

   // Combine into w, pick the branch, seed the square root
   always_comb begin
      p_sum   = P_W'({scale_ff.p1, {WQ{1'b0}}}) - P_W'(scale_ff.p2)
                + (P_W'(1) << (WQ - 1));
      w_val   = p_sum[W_W+WQ-1:WQ];
      tc_full = $signed({1'b0, w_val}) - $signed({1'b0, W_MID});
      sqrt_head_in.valid   = scale_ff.valid;
      sqrt_head_in.tag     = scale_ff.tag;
      sqrt_head_in.central = w_val < W_SPLIT;
      sqrt_head_in.tc      = T_W'(tc_full);
      sqrt_head_in.v       = V_W'({w_val, {WQ{1'b0}}});
      sqrt_head_in.rem     = '0;
      sqrt_head_in.root    = '0;
   end

   assign sqrt_w[0] = sqrt_head_ff;

   // Square root chain
   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      erfinv_sqrt_cell u_sqrt (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .src_word (sqrt_w[i]),
         .dst_word (sqrt_w[i+1])
      );
   end

   // Select t and the leading coefficient of the branch
   always_comb begin
      sel_in.valid   = sqrt_w[ROOT_W].valid;
      sel_in.tag     = sqrt_w[ROOT_W].tag;
      sel_in.central = sqrt_w[ROOT_W].central;
      sel_in.t       = sqrt_w[ROOT_W].central ? sqrt_w[ROOT_W].tc
                       : $signed({1'b0, sqrt_w[ROOT_W].root}) - ROOT_3;
      sel_in.x       = sqrt_w[ROOT_W].central ? CENTRAL_COEF[0] : TAIL_COEF[0];
   end

   assign horner_w[0] = sel_ff;

   // Horner chain
   for (genvar i = 0; i < HORNER_CELLS; i++) begin : g_horner
      erfinv_horner_cell u_horner (
         .clock        (clock),
         .reset        (reset),
         .enable       (advance),
         .coef_central (CENTRAL_COEF[i+1]),
         .coef_tail    (TAIL_COEF[i+1]),
         .src_word     (horner_w[i]),
         .dst_word     (horner_w[i+1])
      );
   end

   // Multiply the polynomial by y
   always_comb begin
      fin_in.valid = horner_w[HORNER_CELLS].valid;
      fin_in.tag   = horner_w[HORNER_CELLS].tag;
      fin_in.prod  = horner_w[HORNER_CELLS].x * horner_w[HORNER_CELLS].tag.y;
   end

   // Round to the output format and saturate
   always_comb begin
      rnd          = (fin_ff.prod + (PROD_W'(1) <<< (RES_SHIFT - 1))) >>> RES_SHIFT;
      res_in.valid = fin_ff.valid;
      if (fin_ff.tag.sat) begin
         res_in.res = fin_ff.tag.y[Y_W-1] ? Y_W'(SAT_LO) : Y_W'(SAT_HI);
      end else if (rnd > SAT_HI) begin
         res_in.res = Y_W'(SAT_HI);
      end else if (rnd < SAT_LO) begin
         res_in.res = Y_W'(SAT_LO);
      end else begin
         res_in.res = Y_W'(rnd);
      end
   end

   // Advance the stages owned by the top level
   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid        <= 1'b0;
         sq_ff.valid        <= 1'b0;
         norm_head_ff.valid <= 1'b0;
         scale_ff.valid     <= 1'b0;
         sqrt_head_ff.valid <= 1'b0;
         sel_ff.valid       <= 1'b0;
         fin_ff.valid       <= 1'b0;
         res_ff.valid       <= 1'b0;
      end else if (advance) begin
         in_ff        <= in_in;
         sq_ff        <= sq_in;
         norm_head_ff <= norm_head_in;
         scale_ff     <= scale_in;
         sqrt_head_ff <= sqrt_head_in;
         sel_ff       <= sel_in;
         fin_ff       <= fin_in;
         res_ff       <= res_in;
      end
   end

   // Output register with one skid slot
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && !rsp_tready) begin
         if (advance && res_ff.valid) begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_ff.res;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = advance && res_ff.valid;
         out_data_in  = res_ff.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // The skid slot only fills behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot valid without output word");

   // A taken output word is refilled from the skid slot
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_tready |=> out_valid_ff && !skid_valid_ff)
      else $error("skid slot did not drain into output register");

   // An empty output register never sends a result to the skid slot
   a_skid_needs_stall: assert property (@(posedge clock) disable iff (reset)
      !skid_valid_ff && !out_valid_ff |=> !skid_valid_ff)
      else $error("skid slot filled while output register was empty");

endmodule

### rtl/core/erfinv_norm_cell.sv
// ----------------------------------------------------------------------------
// erfinv_norm_cell: one step of the leading-zero normalizer
// Strips up to eight leading zeros from the word and adds the count to lz.
// ----------------------------------------------------------------------------
module erfinv_norm_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  erfinv_pkg::norm_word_type src_word,
   output erfinv_pkg::norm_word_type dst_word
);
   import erfinv_pkg::*;

   norm_word_type          word_ff, word_in;
   logic [NORM_STEP-1:0]   top_bits;
   logic [CNT_W-1:0]       zeros;

   // Count leading zeros of the top byte and shift them out
   always_comb begin
      top_bits = src_word.d[D_W-1 -: NORM_STEP];
      zeros    = CNT_W'(NORM_STEP);
      for (int i = 0; i < NORM_STEP; i++) begin
         if (top_bits[i]) begin
            zeros = CNT_W'(NORM_STEP - 1 - i);
         end
      end
      word_in    = src_word;
      word_in.d  = src_word.d << zeros;
      word_in.lz = src_word.lz + LZ_W'(zeros);
   end

   // Advance the word
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (enable) begin
         word_ff <= word_in;
      end
   end

   assign dst_word = word_ff;

endmodule

### rtl/core/erfinv_log_cell.sv
// ----------------------------------------------------------------------------
// erfinv_log_cell: one fraction bit of the bit-serial log2
// Squares the Q1.30 mantissa, takes the carry out as the next fraction bit.
// ----------------------------------------------------------------------------
module erfinv_log_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  erfinv_pkg::log_word_type src_word,
   output erfinv_pkg::log_word_type dst_word
);
   import erfinv_pkg::*;

   log_word_type           word_ff, word_in;
   logic [2*M_W-1:0]       square;
   logic [M_W:0]           scaled;

   // Square, truncate to Q2.30 and renormalize when it reaches two
   always_comb begin
      square       = src_word.m * src_word.m;
      scaled       = square[M_FRAC +: M_W + 1];
      word_in      = src_word;
      word_in.frac = {src_word.frac[WQ-2:0], scaled[M_W]};
      word_in.m    = scaled[M_W] ? scaled[M_W:1] : scaled[M_W-1:0];
   end

   // Advance the word
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (enable) begin
         word_ff <= word_in;
      end
   end

   assign dst_word = word_ff;

endmodule

### rtl/core/erfinv_sqrt_cell.sv
// ----------------------------------------------------------------------------
// erfinv_sqrt_cell: one root bit of the digit-by-digit square root
// Brings down two radicand bits and decides one root bit by trial subtract.
// ----------------------------------------------------------------------------
module erfinv_sqrt_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  erfinv_pkg::sqrt_word_type src_word,
   output erfinv_pkg::sqrt_word_type dst_word
);
   import erfinv_pkg::*;

   sqrt_word_type          word_ff, word_in;
   logic [REM_W+1:0]       partial;
   logic [REM_W+1:0]       trial;

   // Trial subtract of (4*root + 1) from the extended remainder
   always_comb begin
      partial = {src_word.rem, src_word.v[V_W-1 -: 2]};
      trial   = {2'b00, src_word.root, 2'b01};
      word_in = src_word;
      word_in.v = src_word.v << 2;
      if (partial >= trial) begin
         word_in.rem  = REM_W'(partial - trial);
         word_in.root = {src_word.root[ROOT_W-2:0], 1'b1};
      end else begin
         word_in.rem  = REM_W'(partial);
         word_in.root = {src_word.root[ROOT_W-2:0], 1'b0};
      end
   end

   // Advance the word
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (enable) begin
         word_ff <= word_in;
      end
   end

   assign dst_word = word_ff;

endmodule

### rtl/core/erfinv_horner_cell.sv
// ----------------------------------------------------------------------------
// erfinv_horner_cell: one Horner step x = round(x*t / 2^28) + c
// Two registers: split partial products, then sum, round and add the
// coefficient of the item's branch.
// ----------------------------------------------------------------------------
module erfinv_horner_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic signed [erfinv_pkg::X_W-1:0]      coef_central,
   input  logic signed [erfinv_pkg::X_W-1:0]      coef_tail,
   input  erfinv_pkg::horner_word_type            src_word,
   output erfinv_pkg::horner_word_type            dst_word
);
   import erfinv_pkg::*;

   localparam int SUM_W = X_W + T_W + 2;

   typedef struct packed {
      logic                         valid;
      tag_type                      tag;
      logic                         central;
      logic signed [T_W-1:0]        t;
      logic signed [XH_W+T_W-1:0]   ph;
      logic signed [XL_W+T_W:0]     pl;
   } mid_type;

   mid_type                mid_ff, mid_in;
   horner_word_type        word_ff, word_in;
   logic signed [XH_W-1:0] x_hi;
   logic signed [XL_W:0]   x_lo;
   logic signed [SUM_W-1:0] sum;
   logic signed [X_W-1:0]  coef;

   // Form the high and low partial products of x*t
   always_comb begin
      x_hi           = src_word.x[X_W-1:XL_W];
      x_lo           = {1'b0, src_word.x[XL_W-1:0]};
      mid_in.valid   = src_word.valid;
      mid_in.tag     = src_word.tag;
      mid_in.central = src_word.central;
      mid_in.t       = src_word.t;
      mid_in.ph      = x_hi * src_word.t;
      mid_in.pl      = x_lo * src_word.t;
   end

   // Recombine, round half up at bit 28 and add the coefficient
   always_comb begin
      coef = mid_ff.central ? coef_central : coef_tail;
      sum  = (SUM_W'(mid_ff.ph) <<< XL_W) + SUM_W'(mid_ff.pl)
             + (SUM_W'(1) <<< (WQ - 1));
      word_in.valid   = mid_ff.valid;
      word_in.tag     = mid_ff.tag;
      word_in.central = mid_ff.central;
      word_in.t       = mid_ff.t;
      word_in.x       = X_W'(sum >>> WQ) + coef;
   end

   // Advance both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid  <= 1'b0;
         word_ff.valid <= 1'b0;
      end else if (enable) begin
         mid_ff  <= mid_in;
         word_ff <= word_in;
      end
   end

   assign dst_word = word_ff;

endmodule

### tb/sv/inverse_error_function_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_error_function_unit_test: self-checking bench for the erfinv unit
// Drives Q1.23 arguments with random gaps against random result stalls.
// A bit-exact model predicts each Q4.20 result, and every returned word
// is checked in order against the predictions.
// ----------------------------------------------------------------------------

// Bit-exact erfinv predictor and in-order result check
class erfinv_scoreboard;
   localparam int WQ_BITS   = 28;
   localparam int CQ_BITS   = 30;
   localparam int IN_FRAC   = erfinv_pkg::IN_FRAC_BITS;
   localparam int OUT_FRAC  = erfinv_pkg::OUT_FRAC_BITS;
   localparam int SAT_HI    = 8388607;
   localparam int SAT_LO    = -8388608;

   logic signed [23:0] pending_values [$];
   longint             central_c [9];
   longint             tail_c [9];
   longint unsigned    ln2_q28;
   int                 error_count;

   // Round a decimal m / d to nearest Q30
   function longint to_q30(longint m, longint d);
      return (m * (64'sd1 << CQ_BITS) + d / 2) / d;
   endfunction

   function new();
      central_c = '{to_q30(281022636, 64'sd10000000000000000),
                    to_q30(343273939, 64'sd1000000000000000),
                    -to_q30(352338770, 64'sd100000000000000),
                    -to_q30(439150654, 64'sd100000000000000),
                    to_q30(218580870, 64'sd1000000000000),
                    -to_q30(125372503, 64'sd100000000000),
                    -to_q30(417768164, 64'sd100000000000),
                    to_q30(246640727, 64'sd1000000000),
                    to_q30(150140941, 64'sd100000000)};
      tail_c = '{-to_q30(200214257, 64'sd1000000000000),
                 to_q30(100950558, 64'sd1000000000000),
                 to_q30(134934322, 64'sd100000000000),
                 -to_q30(367342844, 64'sd100000000000),
                 to_q30(573950773, 64'sd100000000000),
                 -to_q30(762246130, 64'sd100000000000),
                 to_q30(943887047, 64'sd100000000000),
                 to_q30(100167406, 64'sd100000000),
                 to_q30(283297682, 64'sd100000000)};
      ln2_q28 = (64'd6931471806 * (64'd1 << WQ_BITS) + 64'd5000000000) / 64'd10000000000;
      error_count = 0;
   endfunction

   // floor((p + 2^(sh-1)) / 2^sh)
   function longint round_down_shift(longint p, int sh);
      return (p + (64'sd1 << (sh - 1))) >>> sh;
   endfunction

   function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // -ln(d / 2^(2*IN_FRAC)) in Q28, via normalize, serial log2 and ln 2 scale
   function longint unsigned log_distance(longint unsigned d);
      int              k;
      longint unsigned m;
      longint unsigned frac;
      longint unsigned lg;
      k = 0;
      frac = 0;
      while (k < 63 && (d >> (k + 1)) != 0) k++;
      m = (k >= 30) ? (d >> (k - 30)) : (d << (30 - k));
      for (int i = 0; i < WQ_BITS; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd2 << 30)) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      lg = (longint'(2 * IN_FRAC - k) << WQ_BITS) - frac;
      return (lg * ln2_q28 + (64'd1 << (WQ_BITS - 1))) >> WQ_BITS;
   endfunction

   function logic signed [23:0] predict_inverse(logic signed [23:0] arg);
      longint          y;
      longint unsigned mag;
      longint unsigned unity;
      longint unsigned ysq;
      longint unsigned w;
      longint          t;
      longint          x;
      longint          res;
      logic            central;
      y = arg;
      mag = (y < 0) ? -y : y;
      unity = 64'd1 << (2 * IN_FRAC);
      ysq = mag * mag;
      // Magnitude at or beyond one saturates
      if (ysq >= unity) return (y < 0) ? 24'(SAT_LO) : 24'(SAT_HI);
      w = log_distance(unity - ysq);
      central = (w < (64'd5 << WQ_BITS));
      if (central) t = longint'(w) - (64'sd5 << (WQ_BITS - 1));
      else t = longint'(floor_sqrt(w << WQ_BITS)) - (64'sd3 << WQ_BITS);
      x = central ? central_c[0] : tail_c[0];
      for (int i = 1; i < 9; i++)
         x = round_down_shift(x * t, WQ_BITS) + (central ? central_c[i] : tail_c[i]);
      res = round_down_shift(x * y, CQ_BITS + IN_FRAC - OUT_FRAC);
      if (res > SAT_HI) res = SAT_HI;
      if (res < SAT_LO) res = SAT_LO;
      return 24'(res);
   endfunction

   function void note_argument(logic signed [23:0] arg);
      pending_values.push_back(predict_inverse(arg));
   endfunction

   function void check_result(logic signed [23:0] got);
      logic signed [23:0] want;
      if (pending_values.size() == 0) begin
         $error("inverse_value: no result expected, got %0d", got);
         error_count++;
         return;
      end
      want = pending_values.pop_front();
      if (got !== want) begin
         $error("inverse_value: expected %0d, actual %0d", want, got);
         error_count++;
      end
   endfunction
endclass

module inverse_error_function_unit_test;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 120;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;

   erfinv_scoreboard inverse_book;
   int  cycle_count;
   bit  gaps_on;

   inverse_error_function_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Send one word, with a random gap ahead of it when gaps are on
   task automatic send_argument(logic [23:0] arg);
      int gap;
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = arg;
      do @(posedge clock); while (!req_tready);
      inverse_book.note_argument(arg);
      @(negedge clock);
   endtask

   // Argument near +-1 so the tail branch and the w = 5 boundary get covered
   function automatic logic [23:0] near_unity();
      logic [23:0] mag;
      mag = 24'h7FFFFF - 24'($urandom() & ((32'd1 << $urandom_range(0, 22)) - 1));
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // Check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) inverse_book.check_result(rsp_tdata);
   end

   // Stall the result side: random hold-off per word, with quiet stretches
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = gaps_on ? $urandom_range(0, 8) : 0;
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("inverse_error_function_unit_test NOT OK");
         $finish;
      end
   end

   initial begin
      logic [23:0] directed [$];
      inverse_book = new();
      gaps_on = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Zero, smallest steps, extremes, minus one, halves, deep tail
      directed = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800001,
                   24'h800000, 24'h400000, 24'hC00000, 24'h7FFFFE, 24'h800002,
                   24'h7F0000, 24'h810000, 24'h7FC000, 24'h7FE000, 24'h7FF000,
                   24'h7F8000, 24'h7FFF00, 24'h555555, 24'hAAAAAA, 24'h123456,
                   24'h7FFFF0, 24'h800010};
      foreach (directed[i]) send_argument(directed[i]);

      // Random arguments, half uniform and half close to the range ends
      for (int n = 0; n < 1650; n++) begin
         if (n % 200 == 0) gaps_on = (n % 400 == 0);
         send_argument($urandom_range(0, 1) ? 24'($urandom()) : near_unity());
      end
      req_tvalid = 1'b0;
      gaps_on = 1'b1;

      while (inverse_book.pending_values.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (inverse_book.error_count == 0) begin
         $display("inverse_error_function_unit_test OK");
      end else begin
         $display("inverse_error_function_unit_test NOT OK");
      end
      $finish;
   end
endmodule
